FILE: rtl/core/lruc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg
// Shared types and constants for the LRU page cache: register map,
// configuration struct and sequencer state codes.
// ----------------------------------------------------------------------------
package lruc_pkg;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int CAP_W      = 4;
	localparam int TAG_W      = 32;
	localparam int WORD_W     = 64;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd6;

	// register index is paddr[2]
	localparam logic REG_CAPACITY = 1'b0;

	localparam logic ACT_LOOKUP = 1'b0;
	localparam logic ACT_FILL   = 1'b1;

	typedef struct packed {
		logic [CAP_W-1:0] capacity;
	} cfg_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SCAN   = 6'b000010,
		S_DECIDE = 6'b000100,
		S_AGE    = 6'b001000,
		S_FINISH = 6'b010000,
		S_OUT    = 6'b100000
	} state_t;

endpackage
`default_nettype wire

FILE: rtl/core/lruc_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_regs
// APB register block holding the capacity register.
// ----------------------------------------------------------------------------
module lruc_regs (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [lruc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire [lruc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lruc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output lruc_pkg::cfg_t                 cfg
);
	import lruc_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (wr_en && (paddr[2] == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_CAPACITY) begin
			prdata[CAP_W-1:0] = capacity_q;
		end
	end

	assign cfg.capacity = capacity_q;

endmodule
`default_nettype wire

FILE: rtl/core/lru_cache_with_miss_forward_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_cache_with_miss_forward_core
// Fully associative page cache with LRU replacement; misses go to the server.
// ----------------------------------------------------------------------------
// order: a lookup miss gives its item after the scan sweep alone, a hit after
//   the scan sweep, the ageing sweep and the finish step; fills give no item
// intake: one item at a time (in_stall), paced by the single read port of the
//   tag and rank memories, swept one entry a cycle, once for a miss, twice else
// reset: valid bits and occupancy clear at once, capacity returns to 6, no
//   clearing pass
// ----------------------------------------------------------------------------
module lru_cache_with_miss_forward_core #(
	parameter int ENTRIES = 8,
	parameter int USERS   = 5,
	localparam int UW     = $clog2(USERS + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [lruc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire [lruc_pkg::APB_DATA_W-1:0] pwdata,
	output logic [lruc_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire                            action,
	input  wire [lruc_pkg::TAG_W-1:0]      page_tag,
	input  wire [UW-1:0]                   requester_id,
	input  wire [lruc_pkg::WORD_W-1:0]     fill_data,
	input  wire                            fill_ok,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [UW-1:0]                  dest_port,
	output logic [lruc_pkg::TAG_W-1:0]     out_tag,
	output logic [UW-1:0]                  out_user,
	output logic [lruc_pkg::WORD_W-1:0]    out_data
);
	import lruc_pkg::*;

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] LAST = CW'(ENTRIES);

	cfg_t cfg;

	lruc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// memories
	logic [TAG_W-1:0]  tag_mem  [ENTRIES];
	logic [IW-1:0]     rank_mem [ENTRIES];
	logic [WORD_W-1:0] data_mem [ENTRIES];

	logic [TAG_W-1:0]  tag_rd;
	logic [IW-1:0]     rank_rd;
	logic [WORD_W-1:0] data_rd;

	state_t            state_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]     occ_q;
	logic [CW-1:0]     cnt_q;
	logic              rd_vld_s1;
	logic [IW-1:0]     rd_idx_s1;

	logic              act_q;
	logic [TAG_W-1:0]  tag_q;
	logic [UW-1:0]     user_q;
	logic [WORD_W-1:0] fdata_q;

	logic              hit_q;
	logic [IW-1:0]     hit_idx_q;
	logic [IW-1:0]     hit_rank_q;
	logic              max_found_q;
	logic [IW-1:0]     max_idx_q;
	logic [IW-1:0]     max_rank_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;

	logic [IW-1:0]     tgt_q;
	logic [IW-1:0]     thr_q;
	logic              all_q;
	logic              ins_q;

	logic              out_valid_q;
	logic [UW-1:0]     dest_q;
	logic [TAG_W-1:0]  otag_q;
	logic [UW-1:0]     ouser_q;
	logic [WORD_W-1:0] odata_q;

	logic              accept;
	logic              in_ok;
	logic              issue;
	logic              sweep_done;
	logic              rd_entry_valid;
	logic              room;
	logic              out_load;
	logic              rank_we;
	logic [IW-1:0]     rank_waddr;
	logic [IW-1:0]     rank_wdata;
	logic              tag_we;
	logic              data_re;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign in_ok    = (action == ACT_FILL) ? fill_ok
	                  : ((requester_id != '0) && (requester_id <= UW'(USERS)));

	assign issue      = ((state_q == S_SCAN) || (state_q == S_AGE)) && (cnt_q != LAST);
	assign sweep_done = (cnt_q == LAST);
	assign rd_entry_valid = valid_q[rd_idx_s1];

	// a new tag may take a free slot while below the effective capacity
	assign room = (occ_q < LAST) &&
	              ((cfg.capacity == '0) ? (occ_q == '0)
	                                    : (32'(occ_q) < 32'(cfg.capacity)));

	assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign data_re  = (state_q == S_DECIDE) && hit_q && (act_q == ACT_LOOKUP);
	assign tag_we   = (state_q == S_FINISH) && (act_q == ACT_FILL);

	always_comb begin
		rank_we    = 1'b0;
		rank_waddr = rd_idx_s1;
		rank_wdata = rank_rd + 1'b1;
		if (state_q == S_AGE) begin
			rank_we = rd_vld_s1 && rd_entry_valid && (rd_idx_s1 != tgt_q) &&
			          (all_q || (rank_rd < thr_q));
		end else if (state_q == S_FINISH) begin
			rank_we    = 1'b1;
			rank_waddr = tgt_q;
			rank_wdata = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tgt_q]  <= tag_q;
			data_mem[tgt_q] <= fdata_q;
		end
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
		if (issue) begin
			tag_rd  <= tag_mem[cnt_q[IW-1:0]];
			rank_rd <= rank_mem[cnt_q[IW-1:0]];
		end
		if (data_re) begin
			data_rd <= data_mem[hit_idx_q];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			occ_q     <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept && in_ok) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sweep_done) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					cnt_q <= '0;
					if ((act_q == ACT_LOOKUP) && !hit_q) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_AGE;
					end
				end
				S_AGE: begin
					if (sweep_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (ins_q) begin
						valid_q[tgt_q] <= 1'b1;
						occ_q          <= occ_q + 1'b1;
					end
					state_q <= (act_q == ACT_LOOKUP) ? S_OUT : S_IDLE;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item capture, scan results and replacement decision
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q        <= action;
			tag_q        <= page_tag;
			user_q       <= requester_id;
			fdata_q      <= fill_data;
			hit_q        <= 1'b0;
			max_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end
		if ((state_q == S_SCAN) && rd_vld_s1) begin
			if (rd_entry_valid && (tag_rd == tag_q) && !hit_q) begin
				hit_q      <= 1'b1;
				hit_idx_q  <= rd_idx_s1;
				hit_rank_q <= rank_rd;
			end
			if (rd_entry_valid && (!max_found_q || (rank_rd > max_rank_q))) begin
				max_found_q <= 1'b1;
				max_idx_q   <= rd_idx_s1;
				max_rank_q  <= rank_rd;
			end
			if (!rd_entry_valid && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= rd_idx_s1;
			end
		end
		if (issue) begin
			rd_idx_s1 <= cnt_q[IW-1:0];
		end
		if (state_q == S_DECIDE) begin
			all_q <= 1'b0;
			ins_q <= 1'b0;
			priority if (hit_q) begin
				tgt_q <= hit_idx_q;
				thr_q <= hit_rank_q;
			end else if (room) begin
				tgt_q <= free_idx_q;
				thr_q <= '0;
				all_q <= 1'b1;
				ins_q <= 1'b1;
			end else begin
				tgt_q <= max_idx_q;
				thr_q <= max_rank_q;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (hit_q) begin
				dest_q  <= user_q;
				otag_q  <= '0;
				ouser_q <= '0;
				odata_q <= data_rd;
			end else begin
				dest_q  <= '0;
				otag_q  <= tag_q;
				ouser_q <= user_q;
				odata_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign dest_port = dest_q;
	assign out_tag   = otag_q;
	assign out_user  = ouser_q;
	assign out_data  = odata_q;

`ifndef NO_ASSERTIONS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(occ_q))
		else $error("occupancy differs from valid bit count");

	a_insert_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && ins_q |-> !valid_q[tgt_q])
		else $error("insert targets an occupied entry");

	a_insert_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH) && ins_q |=> valid_q[$past(tgt_q)])
		else $error("inserted entry not marked valid");

	a_age_skips_target: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AGE) && rank_we |-> (rank_waddr != tgt_q))
		else $error("ageing sweep wrote the target entry");
`endif

endmodule
`default_nettype wire

FILE: bench/lru_cache_with_miss_forward_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_with_miss_forward_checker
// Watches the configuration port and both item channels of the LRU page
// cache. It keeps its own copy of the cache contents and recency order,
// works out the reply due for every accepted lookup from a valid requester
// and compares each delivered item field by field with the oldest reply
// due. Capacity read-backs are checked as well.
// ----------------------------------------------------------------------------
module lru_cache_with_miss_forward_checker #(
	parameter int ENTRIES = 8,
	parameter int USERS   = 5,
	parameter int UW      = $clog2(USERS + 1)
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            psel,
	input  wire                            penable,
	input  wire                            pwrite,
	input  wire [lruc_pkg::APB_ADDR_W-1:0] paddr,
	input  wire [lruc_pkg::APB_DATA_W-1:0] pwdata,
	input  wire [lruc_pkg::APB_DATA_W-1:0] prdata,
	input  wire                            pready,
	input  wire                            in_valid,
	input  wire                            in_stall,
	input  wire                            action,
	input  wire [lruc_pkg::TAG_W-1:0]      page_tag,
	input  wire [UW-1:0]                   requester_id,
	input  wire [lruc_pkg::WORD_W-1:0]     fill_data,
	input  wire                            fill_ok,
	input  wire                            out_valid,
	input  wire                            out_stall,
	input  wire [UW-1:0]                   dest_port,
	input  wire [lruc_pkg::TAG_W-1:0]      out_tag,
	input  wire [UW-1:0]                   out_user,
	input  wire [lruc_pkg::WORD_W-1:0]     out_data,
	output int                             mismatches,
	output int                             replies_outstanding
);
	import lruc_pkg::*;

	localparam int RW = $clog2(ENTRIES);
	localparam int OW = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic [UW-1:0]     dest;
		logic [TAG_W-1:0]  tag;
		logic [UW-1:0]     user;
		logic [WORD_W-1:0] word;
	} reply_t;

	logic [CAP_W-1:0]  capacity;
	logic              line_valid [ENTRIES];
	logic [TAG_W-1:0]  line_tag   [ENTRIES];
	logic [WORD_W-1:0] line_word  [ENTRIES];
	logic [RW-1:0]     line_age   [ENTRIES];
	logic [OW-1:0]     lines_used;
	reply_t            replies_due [$];

	function automatic int capacity_in_force();
		if (capacity == 0) return 1;
		if (capacity > ENTRIES) return ENTRIES;
		return int'(capacity);
	endfunction

	function automatic int line_of(logic [TAG_W-1:0] tag);
		for (int i = 0; i < ENTRIES; i++)
			if (line_valid[i] && line_tag[i] == tag) return i;
		return -1;
	endfunction

	// lines newer than k age by one, k becomes the newest
	task automatic make_newest(int k);
		logic [RW-1:0] r;
		r = line_age[k];
		for (int i = 0; i < ENTRIES; i++)
			if (line_valid[i] && i != k && line_age[i] < r) line_age[i]++;
		line_age[k] = '0;
	endtask

	task automatic store_page(logic [TAG_W-1:0] tag, logic [WORD_W-1:0] word);
		int k;
		k = line_of(tag);
		if (k >= 0) begin
			line_word[k] = word;
			make_newest(k);
		end else if (lines_used < capacity_in_force()) begin
			for (int i = ENTRIES - 1; i >= 0; i--)
				if (!line_valid[i]) k = i;
			for (int i = 0; i < ENTRIES; i++)
				if (line_valid[i]) line_age[i]++;
			line_valid[k] = 1'b1;
			line_tag[k]   = tag;
			line_word[k]  = word;
			line_age[k]   = '0;
			lines_used++;
		end else begin
			// evict the oldest line and reuse it
			for (int i = 0; i < ENTRIES; i++)
				if (line_valid[i] && (k < 0 || line_age[i] > line_age[k])) k = i;
			line_tag[k]  = tag;
			line_word[k] = word;
			make_newest(k);
		end
	endtask

	task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		int k;
		if (!arst_n) begin
			capacity = CAP_RESET;
			for (int i = 0; i < ENTRIES; i++) line_valid[i] = 1'b0;
			lines_used = '0;
			replies_due.delete();
			replies_outstanding <= 0;
		end else begin
			if (psel && penable && pready && paddr[2] == REG_CAPACITY) begin
				if (pwrite)
					capacity = pwdata[CAP_W-1:0];
				else
					check_field("capacity", capacity, prdata[CAP_W-1:0]);
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("item with none due: dest_port %0d out_tag 0x%0h", dest_port, out_tag);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("dest_port", want.dest, dest_port);
					check_field("out_tag", want.tag, out_tag);
					check_field("out_user", want.user, out_user);
					check_field("out_data", want.word, out_data);
				end
			end
			if (in_valid && !in_stall) begin
				if (action == ACT_FILL) begin
					if (fill_ok) store_page(page_tag, fill_data);
				end else if (requester_id != 0 && requester_id <= USERS) begin
					k = line_of(page_tag);
					if (k >= 0) begin
						make_newest(k);
						want.dest = requester_id;
						want.tag  = '0;
						want.user = '0;
						want.word = line_word[k];
					end else begin
						want.dest = '0;
						want.tag  = page_tag;
						want.user = requester_id;
						want.word = '0;
					end
					replies_due.push_back(want);
				end
			end
			replies_outstanding <= replies_due.size();
		end
	end

endmodule

FILE: bench/lru_cache_with_miss_forward_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_cache_with_miss_forward_core_test
// Drives the LRU page cache with directed lookups and fills, then random
// phases of mostly reused page tags under a range of capacity settings,
// with random gaps on the input side and random stalls on the output side.
// The checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module lru_cache_with_miss_forward_core_test;
	import lruc_pkg::*;

	localparam int ENTRIES = 8;
	localparam int USERS   = 5;
	localparam int UW      = $clog2(USERS + 1);
	localparam int PHASE_ITEMS = 168;
	localparam logic [APB_ADDR_W-1:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
	localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_CAPACITY, 2'b00};
	localparam logic [APB_DATA_W-1:0] CAP_PLAN [10] = '{
		32'd8, 32'd1, 32'd0, 32'd15, 32'hFFFF_FFF3, 32'd7, 32'd2, 32'd5, 32'd4, 32'd6
	};

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  psel         = 1'b0;
	logic                  penable      = 1'b0;
	logic                  pwrite       = 1'b0;
	logic [APB_ADDR_W-1:0] paddr        = '0;
	logic [APB_DATA_W-1:0] pwdata       = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic                  action       = ACT_LOOKUP;
	logic [TAG_W-1:0]      page_tag     = '0;
	logic [UW-1:0]         requester_id = '0;
	logic [WORD_W-1:0]     fill_data    = '0;
	logic                  fill_ok      = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [UW-1:0]         dest_port;
	logic [TAG_W-1:0]      out_tag;
	logic [UW-1:0]         out_user;
	logic [WORD_W-1:0]     out_data;
	int                    mismatches;
	int                    replies_outstanding;
	bit                    quiet = 1'b0;

	lru_cache_with_miss_forward_core #(.ENTRIES(ENTRIES), .USERS(USERS)) dut (.*);

	lru_cache_with_miss_forward_checker #(.ENTRIES(ENTRIES), .USERS(USERS)) u_checker (.*);

	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// output side stall bursts
	initial begin
		int n;
		bit hold;
		forever begin
			n = $urandom_range(1, 13);
			hold = ($urandom_range(0, 2) == 0);
			repeat (n) begin
				@(negedge clk);
				out_stall = hold && !quiet;
			end
		end
	end

	task automatic send_item(logic act, logic [TAG_W-1:0] tag, logic [UW-1:0] user,
			logic [WORD_W-1:0] word, logic ok);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 13);
			@(negedge clk);
			in_valid  = 1'b0;
			page_tag  = $urandom;
			fill_data = {$urandom, $urandom};
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid     = 1'b1;
		action       = act;
		page_tag     = tag;
		requester_id = user;
		fill_data    = word;
		fill_ok      = ok;
		do @(posedge clk); while (in_stall);
	endtask

	// wait until every reply is in and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (replies_outstanding != 0) @(negedge clk);
		repeat (2 * ENTRIES + 10) @(negedge clk);
	endtask

	task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = wr;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic run_phase(int count);
		logic [TAG_W-1:0] pool [16];
		logic [UW-1:0] user;
		int plen;
		int pick;
		plen = $urandom_range(2, 14);
		for (int i = 0; i < 16; i++) pool[i] = $urandom;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			user = UW'($urandom_range(1, USERS));
			if ($urandom_range(0, 99) < 8)
				user = ($urandom_range(0, 2) == 0) ? UW'(0) : UW'($urandom_range(USERS + 1, 7));
			if (pick < 50)
				send_item(ACT_LOOKUP, pool[$urandom_range(0, plen - 1)], user,
					{$urandom, $urandom}, 1'($urandom_range(0, 1)));
			else if (pick < 60)
				send_item(ACT_LOOKUP, $urandom, user, {$urandom, $urandom},
					1'($urandom_range(0, 1)));
			else
				send_item(ACT_FILL, pool[$urandom_range(0, plen - 1)],
					UW'($urandom_range(0, 7)), {$urandom, $urandom}, pick < 92);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		apb_access(1'b0, CAP_ADDR, '0);

		// directed part at the reset capacity
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd1, '0, 1'b0);
		send_item(ACT_FILL, 32'h0000_0000, 3'd0, 64'h0, 1'b1);
		send_item(ACT_FILL, 32'hFFFF_FFFF, 3'd0, {64{1'b1}}, 1'b1);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd5, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 3'd1, {64{1'b1}}, 1'b1);
		send_item(ACT_FILL, 32'h0000_1234, 3'd2, 64'hDEAD_BEEF_0000_0001, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_1234, 3'd3, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd0, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd6, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd7, '0, 1'b0);
		send_item(ACT_FILL, 32'h0000_0000, 3'd7, 64'h0123_4567_89AB_CDEF, 1'b1);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd2, '0, 1'b0);
		for (int i = 1; i <= 6; i++)
			send_item(ACT_FILL, TAG_W'(i), 3'd0, {32'hA5A5_0000, 32'(i)}, 1'b1);
		send_item(ACT_LOOKUP, 32'hFFFF_FFFF, 3'd4, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0001, 3'd1, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0006, 3'd5, '0, 1'b0);
		send_item(ACT_LOOKUP, 32'h0000_0000, 3'd3, '0, 1'b0);

		for (int p = 0; p < 10; p++) begin
			settle();
			apb_access(1'b1, CAP_ADDR, CAP_PLAN[p]);
			apb_access(1'b0, CAP_ADDR, '0);
			if (p == 4) begin
				apb_access(1'b1, SPARE_ADDR, $urandom);
				apb_access(1'b0, CAP_ADDR, '0);
			end
			if (p == 9) quiet = 1'b1;
			run_phase(PHASE_ITEMS);
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
